// ===== design/ut2cd_pkg.sv =====
// ut2cd_pkg: shared types, stage counts and constants of the unix time to calendar converter
// no dependencies; compiled before the interfaces and all modules

package ut2cd_pkg;

  // pipeline depth of each section
  localparam int unsigned TOD_STAGES  = 7;
  localparam int unsigned DATE_STAGES = 7;
  localparam int unsigned WDAY_STAGES = 5;
  localparam int unsigned N_STAGES    = TOD_STAGES + DATE_STAGES + WDAY_STAGES;

  // time of day split: t / 86400 done as (t >> 7) / 675
  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned DAY_POW2  = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned DAY_SH    = 34;
  localparam logic [24:0] DAY_M     =
    25'(((64'd1 << DAY_SH) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned HOUR_SH   = 29;
  localparam logic [17:0] HOUR_M    =
    18'(((64'd1 << HOUR_SH) + 64'(HOUR_SECS) - 64'd1) / 64'(HOUR_SECS));
  localparam int unsigned MIN_SECS  = 60;
  localparam int unsigned MIN_SH    = 18;
  localparam logic [12:0] MIN_M     =
    13'(((64'd1 << MIN_SH) + 64'(MIN_SECS) - 64'd1) / 64'(MIN_SECS));

  // julian day style date formulas
  localparam int unsigned JD_A_OFS    = 102032;
  localparam int unsigned JD_A_DIV    = 146097;
  localparam int unsigned JD_A_BASE   = 15;
  localparam int unsigned JD_B_OFS    = 2442113;
  localparam int unsigned JD_C_OFS    = 2442;
  localparam int unsigned JD_C_DIV    = 7305;
  localparam int unsigned C_SH        = 39;
  localparam logic [26:0] C_M         =
    27'(((64'd1 << C_SH) + 64'(JD_C_DIV) - 64'd1) / 64'(JD_C_DIV));
  localparam int unsigned YEAR_DAYS   = 365;
  localparam int unsigned E_SCALE     = 1000;
  localparam int unsigned E_DIV       = 30601;
  localparam int unsigned E_SH        = 34;
  localparam logic [19:0] E_M         =
    20'(((64'd1 << E_SH) + 64'(E_DIV) - 64'd1) / 64'(E_DIV));
  localparam int unsigned MONTH_WRAP  = 13;
  localparam int unsigned YEAR_OFS_LO = 4716;
  localparam int unsigned YEAR_OFS_HI = 4715;

  // 30*e + (601*e)/1000, indexed by e
  localparam logic [8:0] EOFF_TAB [16] = '{
    9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // zeller congruence
  localparam int unsigned CENT        = 100;
  localparam int unsigned CENT_SH     = 18;
  localparam logic [11:0] CENT_M      =
    12'(((64'd1 << CENT_SH) + 64'(CENT) - 64'd1) / 64'(CENT));
  localparam int unsigned CENT_WEIGHT = 5;
  localparam int unsigned WDAY_BIAS   = 5;
  localparam int unsigned WEEK_DAYS   = 7;
  localparam int unsigned WEEK_SH     = 12;
  localparam logic [9:0]  WEEK_M      =
    10'(((64'd1 << WEEK_SH) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

  // (26 * (m + 1)) / 10, indexed by zeller month m
  localparam logic [5:0] ZELLER_TAB [16] = '{
    6'd2, 6'd5, 6'd7, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
    6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic [14:0] days;
    hms_t        hms;
  } tod_t;

  typedef struct packed {
    hms_t        hms;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
  } date_t;

  typedef struct packed {
    date_t      date;
    logic [2:0] weekday;
  } cal_t;

endpackage

// ===== design/ut2cd_in_if.sv =====
// ut2cd_in_if: valid/ready channel carrying one signed unix time in seconds
// no dependencies

interface ut2cd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

// ===== design/ut2cd_out_if.sv =====
// ut2cd_out_if: valid/ready channel carrying one calendar date with time of day
// no dependencies

interface ut2cd_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [10:0] year;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [2:0] weekday;

  modport source (output valid, output second, output minute, output hour, output year,
                  output month, output day_of_month, output weekday, input ready);
  modport sink (input valid, input second, input minute, input hour, input year,
                input month, input day_of_month, input weekday, output ready);
endinterface

// ===== design/ut2cd_tod.sv =====
// ut2cd_tod: splits clamped seconds into day count, hour, minute and second
// depends on ut2cd_pkg; stage loads are driven by the top level

module ut2cd_tod (
  input  logic                                clk_i,
  input  logic [ut2cd_pkg::TOD_STAGES-1:0]    en_i,
  input  logic [30:0]                         secs_i,
  output ut2cd_pkg::tod_t                     tod_o
);
  import ut2cd_pkg::*;

  logic [30:0] t1_q, t2_q;
  logic [48:0] pday_d, pday_q;
  logic [14:0] days2_d, days2_q, days3_q, days4_q, days5_q, days6_q;
  logic [16:0] sod3_d, sod3_q, sod4_q;
  logic [34:0] phr4_d, phr4_q;
  logic [4:0]  hour5_d, hour5_q, hour6_q;
  logic [11:0] rem5_d, rem5_q, rem6_q;
  logic [24:0] pmin6_d, pmin6_q;
  logic [5:0]  minute7_d, second7_d;
  tod_t        tod_q;

  always_comb begin
    pday_d    = 49'(secs_i[30:DAY_POW2]) * 49'(DAY_M);
    days2_d   = pday_q[DAY_SH +: 15];
    sod3_d    = 17'(t2_q - 31'(days2_q) * 31'(DAY_SECS));
    phr4_d    = 35'(sod3_q) * 35'(HOUR_M);
    hour5_d   = phr4_q[HOUR_SH +: 5];
    rem5_d    = 12'(sod4_q - 17'(hour5_d) * 17'(HOUR_SECS));
    pmin6_d   = 25'(rem5_q) * 25'(MIN_M);
    minute7_d = pmin6_q[MIN_SH +: 6];
    second7_d = 6'(rem6_q - 12'(minute7_d) * 12'(MIN_SECS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q   <= secs_i;
      pday_q <= pday_d;
    end
    if (en_i[1]) begin
      t2_q    <= t1_q;
      days2_q <= days2_d;
    end
    if (en_i[2]) begin
      days3_q <= days2_q;
      sod3_q  <= sod3_d;
    end
    if (en_i[3]) begin
      days4_q <= days3_q;
      sod4_q  <= sod3_q;
      phr4_q  <= phr4_d;
    end
    if (en_i[4]) begin
      days5_q <= days4_q;
      hour5_q <= hour5_d;
      rem5_q  <= rem5_d;
    end
    if (en_i[5]) begin
      days6_q <= days5_q;
      hour6_q <= hour5_q;
      rem6_q  <= rem5_q;
      pmin6_q <= pmin6_d;
    end
    if (en_i[6]) begin
      tod_q.days       <= days6_q;
      tod_q.hms.hour   <= hour6_q;
      tod_q.hms.minute <= minute7_d;
      tod_q.hms.second <= second7_d;
    end
  end

  assign tod_o = tod_q;

endmodule

// ===== design/ut2cd_date.sv =====
// ut2cd_date: turns the day count into gregorian year, month and day of month
// depends on ut2cd_pkg; time of day fields ride along unchanged

module ut2cd_date (
  input  logic                                clk_i,
  input  logic [ut2cd_pkg::DATE_STAGES-1:0]   en_i,
  input  ut2cd_pkg::tod_t                     tod_i,
  output ut2cd_pkg::date_t                    date_o
);
  import ut2cd_pkg::*;

  logic        a_hi;
  logic [4:0]  a1;
  logic [21:0] b1_d, b1_q, b2_q, b3_q;
  logic [25:0] n2_d, n2_q;
  logic [52:0] pc3_d, pc3_q;
  logic [12:0] c4_d, c4_q, c5_q, c6_q;
  logic [8:0]  d4_d, d4_q, d5_q, d6_q;
  logic [18:0] ne5_d, ne5_q;
  logic [38:0] pe6_d, pe6_q;
  logic [3:0]  e7;
  hms_t        hms1_q, hms2_q, hms3_q, hms4_q, hms5_q, hms6_q;
  date_t       date7_d, date_q;

  always_comb begin
    // a is 15 or 16 over the whole input range
    a_hi  = (18'({tod_i.days, 2'b00}) + 18'(JD_A_OFS)) >= 18'(JD_A_DIV);
    a1    = 5'(JD_A_BASE) + 5'(a_hi);
    b1_d  = 22'(tod_i.days) + 22'(JD_B_OFS) + 22'(a1) - 22'(a1 >> 2);
    n2_d  = (26'(b1_q) << 4) + (26'(b1_q) << 2) - 26'(JD_C_OFS);
    pc3_d = 53'(n2_q) * 53'(C_M);
    c4_d  = pc3_q[C_SH +: 13];
    d4_d  = 9'(22'(b3_q) - 22'(c4_d) * 22'(YEAR_DAYS) - 22'(c4_d >> 2));
    ne5_d = 19'(d4_q) * 19'(E_SCALE);
    pe6_d = 39'(ne5_q) * 39'(E_M);

    e7           = pe6_q[E_SH +: 4];
    date7_d.hms  = hms6_q;
    date7_d.mday = 5'(d6_q - EOFF_TAB[e7]);
    if (e7 <= 4'(MONTH_WRAP)) begin
      date7_d.year  = 11'(c6_q - 13'(YEAR_OFS_LO));
      date7_d.month = e7 - 4'd1;
    end else begin
      date7_d.year  = 11'(c6_q - 13'(YEAR_OFS_HI));
      date7_d.month = e7 - 4'(MONTH_WRAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      b1_q   <= b1_d;
      hms1_q <= tod_i.hms;
    end
    if (en_i[1]) begin
      b2_q   <= b1_q;
      n2_q   <= n2_d;
      hms2_q <= hms1_q;
    end
    if (en_i[2]) begin
      b3_q   <= b2_q;
      pc3_q  <= pc3_d;
      hms3_q <= hms2_q;
    end
    if (en_i[3]) begin
      c4_q   <= c4_d;
      d4_q   <= d4_d;
      hms4_q <= hms3_q;
    end
    if (en_i[4]) begin
      c5_q   <= c4_q;
      d5_q   <= d4_q;
      ne5_q  <= ne5_d;
      hms5_q <= hms4_q;
    end
    if (en_i[5]) begin
      c6_q   <= c5_q;
      d6_q   <= d5_q;
      pe6_q  <= pe6_d;
      hms6_q <= hms5_q;
    end
    if (en_i[6]) begin
      date_q <= date7_d;
    end
  end

  assign date_o = date_q;

endmodule

// ===== design/ut2cd_wday.sv =====
// ut2cd_wday: weekday by zeller congruence, 1 monday through 7 sunday
// depends on ut2cd_pkg; date and time fields ride along unchanged

module ut2cd_wday (
  input  logic                                clk_i,
  input  logic [ut2cd_pkg::WDAY_STAGES-1:0]   en_i,
  input  ut2cd_pkg::date_t                    date_i,
  output ut2cd_pkg::cal_t                     cal_o
);
  import ut2cd_pkg::*;

  logic        early;
  logic [10:0] zy1_d, zy1_q;
  logic [3:0]  zm1_d, zm1_q, zm2_q;
  logic [22:0] pcent1_d, pcent1_q;
  logic [4:0]  cent2_d, cent2_q;
  logic [6:0]  yoc2_d, yoc2_q;
  logic [8:0]  hh3_d, hh3_q, hh4_q;
  logic [18:0] pw4_d, pw4_q;
  logic [6:0]  q5;
  logic [2:0]  r5;
  date_t       date1_q, date2_q, date3_q, date4_q;
  cal_t        cal_q;

  always_comb begin
    // january and february count as months 13 and 14 of the year before
    early    = date_i.month <= 4'd2;
    zy1_d    = early ? date_i.year - 11'd1 : date_i.year;
    zm1_d    = early ? date_i.month + 4'd12 : date_i.month;
    pcent1_d = 23'(zy1_d) * 23'(CENT_M);
    cent2_d  = pcent1_q[CENT_SH +: 5];
    yoc2_d   = 7'(zy1_q - 11'(cent2_d) * 11'(CENT));
    hh3_d    = 9'(date2_q.mday) + 9'(ZELLER_TAB[zm2_q]) + 9'(yoc2_q) + 9'(yoc2_q >> 2)
             + 9'(cent2_q) * 9'(CENT_WEIGHT) + 9'(cent2_q >> 2) + 9'(WDAY_BIAS);
    pw4_d    = 19'(hh3_q) * 19'(WEEK_M);
    q5       = pw4_q[WEEK_SH +: 7];
    r5       = 3'(hh4_q - 9'(q5) * 9'(WEEK_DAYS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zy1_q    <= zy1_d;
      zm1_q    <= zm1_d;
      pcent1_q <= pcent1_d;
      date1_q  <= date_i;
    end
    if (en_i[1]) begin
      cent2_q <= cent2_d;
      yoc2_q  <= yoc2_d;
      zm2_q   <= zm1_q;
      date2_q <= date1_q;
    end
    if (en_i[2]) begin
      hh3_q   <= hh3_d;
      date3_q <= date2_q;
    end
    if (en_i[3]) begin
      hh4_q   <= hh3_q;
      pw4_q   <= pw4_d;
      date4_q <= date3_q;
    end
    if (en_i[4]) begin
      cal_q.date    <= date4_q;
      cal_q.weekday <= r5 + 3'd1;
    end
  end

  assign cal_o = cal_q;

endmodule

// ===== design/unix_time_to_calendar_date.sv =====
// unix_time_to_calendar_date: top level, unix seconds to date, time of day and weekday
// depends on ut2cd_pkg, ut2cd_in_if, ut2cd_out_if, ut2cd_tod, ut2cd_date, ut2cd_wday
//
//   port          dir  payload                                        meaning
//   unix_time_i   in   unix_seconds (s32)                              seconds since epoch
//   cal_date_o    out  second, minute, hour, year, month,              calendar result
//                      day_of_month, weekday
//
// one transfer in and one transfer out per cycle, sustained while cal_date_o.ready is high;
// the datapath is a chain of reciprocal multiplies, each followed by a register
// reset clears only the stage valid bits; data registers are not reset
// each stage holds while it is full and the stage after it cannot load, so bubbles close up and
// ready drops only when all 19 stages hold an item

module unix_time_to_calendar_date (
  input  logic         clk_i,
  input  logic         rst_ni,
  ut2cd_in_if.sink     unix_time_i,
  ut2cd_out_if.source  cal_date_o
);
  import ut2cd_pkg::*;

  localparam int unsigned LAST = N_STAGES - 1;

  logic [N_STAGES-1:0] v_d, v_q;
  logic [N_STAGES-1:0] en;
  logic [30:0]         secs;
  tod_t                tod;
  date_t               date;
  cal_t                cal;

  // stage k may load when it is empty or its item moves on this cycle
  assign en[LAST] = !v_q[LAST] || cal_date_o.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  // valid bits travel with the data
  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = unix_time_i.valid;
    end
    for (int k = 1; k < N_STAGES; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign unix_time_i.ready = en[0];

  // negative and zero times clamp to the epoch
  assign secs = unix_time_i.unix_seconds[31] ? '0 : unix_time_i.unix_seconds[30:0];

  // hour, minute, second and day count
  ut2cd_tod u_tod (
    .clk_i  (clk_i),
    .en_i   (en[TOD_STAGES-1:0]),
    .secs_i (secs),
    .tod_o  (tod)
  );

  // year, month, day of month
  ut2cd_date u_date (
    .clk_i  (clk_i),
    .en_i   (en[TOD_STAGES +: DATE_STAGES]),
    .tod_i  (tod),
    .date_o (date)
  );

  // weekday; its last stage is the output register
  ut2cd_wday u_wday (
    .clk_i  (clk_i),
    .en_i   (en[LAST -: WDAY_STAGES]),
    .date_i (date),
    .cal_o  (cal)
  );

  assign cal_date_o.valid        = v_q[LAST];
  assign cal_date_o.second       = cal.date.hms.second;
  assign cal_date_o.minute       = cal.date.hms.minute;
  assign cal_date_o.hour         = cal.date.hms.hour;
  assign cal_date_o.year         = cal.date.year;
  assign cal_date_o.month        = cal.date.month;
  assign cal_date_o.day_of_month = cal.date.mday;
  assign cal_date_o.weekday      = cal.weekday;

  // input stalls only when every stage holds an item
  a_no_bubble_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !unix_time_i.ready |-> (&v_q))
    else $error("input stalled while the pipeline has a bubble");

  // time of day fields stay in range, catches a reciprocal slip
  a_tod_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_date_o.valid |-> (cal_date_o.second < 6'd60 && cal_date_o.minute < 6'd60 &&
                          cal_date_o.hour < 5'd24))
    else $error("time of day field out of range");

  // date fields stay in range
  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_date_o.valid |-> (cal_date_o.year >= 11'd1970 && cal_date_o.year <= 11'd2038 &&
                          cal_date_o.month >= 4'd1 && cal_date_o.month <= 4'd12 &&
                          cal_date_o.day_of_month != 5'd0 && cal_date_o.weekday != 3'd0))
    else $error("date field out of range");

endmodule
